// File: hw/rtl/rtd_pkg.sv
// rtd_pkg: shared widths, constants and controller/datapath handshake structs
// for the rtime decompressor; no dependencies
package rtd_pkg;

   localparam int CfgW      = 13;
   localparam int ByteW     = 8;
   localparam int CntW      = 3;
   localparam int Symbols   = 256;
   localparam int PackBytes = 4;

   localparam logic [CfgW-1:0] BlenReset = 13'd4096;

   // commands from the controller to the datapath
   typedef struct packed {
      logic accept;    // latch a new pair word
      logic lit_step;  // emit the literal and update the position table
      logic lookup;    // take the copy source from the table read
      logic copy_rd;   // read history at the copy source
      logic copy_wr;   // emit the byte read from history
      logic push;      // move a full pack into the output register
      logic flush;     // move the last pack of a pair out, with block flags
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic finished;
      logic len_reached;
      logic src_stale;
      logic rep_zero;
      logic pack_full;
      logic out_free;
   } sts_type;

endpackage

// File: hw/rtl/rtd_req_if.sv
// rtd_req_if: input channel carrying one (literal, repeat) pair word
// depends on rtd_pkg
interface rtd_req_if;
   logic                      valid;
   logic                      ready;
   logic                      first_pair;
   logic [rtd_pkg::ByteW-1:0] literal;
   logic [rtd_pkg::ByteW-1:0] repeat_count;
   logic                      last_pair;

   modport source (output valid, first_pair, literal, repeat_count, last_pair, input ready);
   modport sink   (input valid, first_pair, literal, repeat_count, last_pair, output ready);
endinterface

// File: hw/rtl/rtd_rsp_if.sv
// rtd_rsp_if: result channel carrying up to four decoded bytes and block flags
// depends on rtd_pkg
interface rtd_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rtd_pkg::ByteW-1:0] byte_a;
   logic [rtd_pkg::ByteW-1:0] byte_b;
   logic [rtd_pkg::ByteW-1:0] byte_c;
   logic [rtd_pkg::ByteW-1:0] byte_d;
   logic [rtd_pkg::CntW-1:0]  byte_count;
   logic                      block_done;
   logic                      short_block;
   logic                      run_end;

   modport source (output valid, byte_a, byte_b, byte_c, byte_d, byte_count,
                   block_done, short_block, run_end, input ready);
   modport sink   (input valid, byte_a, byte_b, byte_c, byte_d, byte_count,
                   block_done, short_block, run_end, output ready);
endinterface

// File: hw/rtl/rtd_ctrl.sv
// rtd_ctrl: sequencer for one pair word: literal, table lookup, copy loop, flush
// depends on rtd_pkg
module rtd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rtd_pkg::sts_type sts,
   output rtd_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_LOOKUP,
      ST_CHECK,
      ST_COPY,
      ST_FLUSH
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            priority if (sts.finished) begin
               state_in = ST_IDLE;
            end else if (sts.len_reached) begin
               state_in = ST_FLUSH;
            end else begin
               cmd.lit_step = 1'b1;
               state_in     = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.lookup = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (sts.rep_zero || sts.len_reached || sts.src_stale) begin
               state_in = ST_FLUSH;
            end else if (sts.pack_full) begin
               // drain a full pack before the next copied byte
               cmd.push = sts.out_free;
            end else begin
               cmd.copy_rd = 1'b1;
               state_in    = ST_COPY;
            end
         end
         ST_COPY: begin
            cmd.copy_wr = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/rtd_datapath.sv
// rtd_datapath: history and position memories, counters, byte packing and
// the output register; depends on rtd_pkg, driven by rtd_ctrl commands
module rtd_datapath #(
   parameter int MAX_BLOCK = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [rtd_pkg::CfgW-1:0]           csr_wr_data,
   input  logic                               req_first_pair,
   input  logic [rtd_pkg::ByteW-1:0]          req_literal,
   input  logic [rtd_pkg::ByteW-1:0]          req_repeat_count,
   input  logic                               req_last_pair,
   input  rtd_pkg::cmd_type                   cmd,
   output rtd_pkg::sts_type                   sts,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [rtd_pkg::PackBytes-1:0][rtd_pkg::ByteW-1:0] rsp_bytes,
   output logic [rtd_pkg::CntW-1:0]           rsp_byte_count,
   output logic                               rsp_block_done,
   output logic                               rsp_short_block,
   output logic                               rsp_run_end
);

   localparam int CW = $clog2(MAX_BLOCK + 1);
   localparam int AW = $clog2(MAX_BLOCK);
   localparam int LW = (CW > rtd_pkg::CfgW) ? CW : rtd_pkg::CfgW;

   // memories
   logic [rtd_pkg::ByteW-1:0] hist_mem [MAX_BLOCK];
   logic [CW-1:0]             ls_mem   [rtd_pkg::Symbols];

   // registers
   logic [rtd_pkg::CfgW-1:0]    blen_ff, blen_in;
   logic [CW-1:0]               out_count_ff, out_count_in;
   logic                        finished_ff, finished_in;
   logic [rtd_pkg::Symbols-1:0] valid_ff, valid_in;
   logic [rtd_pkg::ByteW-1:0]   lit_ff, lit_in;
   logic [rtd_pkg::ByteW-1:0]   rep_ff, rep_in;
   logic                        last_ff, last_in;
   logic [CW-1:0]               src_ff, src_in;
   logic [CW-1:0]               ls_rd_ff;
   logic                        vld_rd_ff;
   logic [rtd_pkg::ByteW-1:0]   hist_rd_ff;
   logic [rtd_pkg::PackBytes-1:0][rtd_pkg::ByteW-1:0] pack_ff, pack_in;
   logic [rtd_pkg::CntW-1:0]    pack_cnt_ff, pack_cnt_in;
   logic                        out_valid_ff, out_valid_in;
   logic [rtd_pkg::PackBytes-1:0][rtd_pkg::ByteW-1:0] out_bytes_ff, out_bytes_in;
   logic [rtd_pkg::CntW-1:0]    out_cnt_ff, out_cnt_in;
   logic                        out_done_ff, out_done_in;
   logic                        out_short_ff, out_short_in;
   logic                        out_end_ff, out_end_in;

   // effective length and byte source
   logic [LW-1:0]             blen_ext;
   logic [LW-1:0]             max_ext;
   logic [CW-1:0]             eff_len;
   logic                      len_reached;
   logic                      done;
   logic                      wr_en;
   logic [rtd_pkg::ByteW-1:0] wr_byte;

   assign blen_ext    = LW'(blen_ff);
   assign max_ext     = LW'(MAX_BLOCK);
   assign eff_len     = (blen_ext < max_ext) ? CW'(blen_ext) : CW'(MAX_BLOCK);
   assign len_reached = (out_count_ff >= eff_len);
   assign done        = len_reached || last_ff;
   assign wr_en       = cmd.lit_step || cmd.copy_wr;
   assign wr_byte     = cmd.lit_step ? lit_ff : hist_rd_ff;

   // status to the controller
   assign sts.finished    = finished_ff;
   assign sts.len_reached = len_reached;
   assign sts.src_stale   = (src_ff >= out_count_ff);
   assign sts.rep_zero    = (rep_ff == '0);
   assign sts.pack_full   = (pack_cnt_ff == rtd_pkg::CntW'(rtd_pkg::PackBytes));
   assign sts.out_free    = !out_valid_ff || rsp_ready;

   // next-state logic
   always_comb begin
      blen_in      = blen_ff;
      out_count_in = out_count_ff;
      finished_in  = finished_ff;
      valid_in     = valid_ff;
      lit_in       = lit_ff;
      rep_in       = rep_ff;
      last_in      = last_ff;
      src_in       = src_ff;
      pack_in      = pack_ff;
      pack_cnt_in  = pack_cnt_ff;
      out_valid_in = out_valid_ff;
      out_bytes_in = out_bytes_ff;
      out_cnt_in   = out_cnt_ff;
      out_done_in  = out_done_ff;
      out_short_in = out_short_ff;
      out_end_in   = out_end_ff;

      // config write
      if (csr_wr_en) begin
         blen_in = csr_wr_data;
      end

      // new pair word, block restart
      if (cmd.accept) begin
         lit_in  = req_literal;
         rep_in  = req_repeat_count;
         last_in = req_last_pair;
         if (req_first_pair) begin
            valid_in     = '0;
            out_count_in = '0;
            finished_in  = 1'b0;
         end
      end

      // literal marks its symbol as seen
      if (cmd.lit_step) begin
         valid_in[lit_ff] = 1'b1;
      end

      // copy source from the position table
      if (cmd.lookup) begin
         src_in = vld_rd_ff ? ls_rd_ff : '0;
      end

      if (cmd.copy_rd) begin
         rep_in = rep_ff - 8'd1;
      end

      if (cmd.copy_wr) begin
         src_in = src_ff + CW'(1);
      end

      // emitted byte goes into the pack
      if (wr_en) begin
         out_count_in                = out_count_ff + CW'(1);
         pack_in[pack_cnt_ff[1:0]]   = wr_byte;
         pack_cnt_in                 = pack_cnt_ff + rtd_pkg::CntW'(1);
      end

      // output register
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.push || cmd.flush) begin
         out_valid_in = 1'b1;
         out_cnt_in   = pack_cnt_ff;
         for (int i = 0; i < rtd_pkg::PackBytes; i++) begin
            out_bytes_in[i] = (rtd_pkg::CntW'(i) < pack_cnt_ff) ? pack_ff[i] : '0;
         end
         pack_cnt_in  = '0;
         out_done_in  = cmd.flush && done;
         out_short_in = cmd.flush && done && !len_reached;
         out_end_in   = cmd.flush;
      end
      if (cmd.flush) begin
         finished_in = done;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         blen_ff      <= rtd_pkg::BlenReset;
         out_count_ff <= '0;
         finished_ff  <= 1'b0;
         valid_ff     <= '0;
         rep_ff       <= '0;
         pack_cnt_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         blen_ff      <= blen_in;
         out_count_ff <= out_count_in;
         finished_ff  <= finished_in;
         valid_ff     <= valid_in;
         rep_ff       <= rep_in;
         pack_cnt_ff  <= pack_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lit_ff       <= lit_in;
      last_ff      <= last_in;
      src_ff       <= src_in;
      pack_ff      <= pack_in;
      out_bytes_ff <= out_bytes_in;
      out_cnt_ff   <= out_cnt_in;
      out_done_ff  <= out_done_in;
      out_short_ff <= out_short_in;
      out_end_ff   <= out_end_in;
   end

   // position table: read returns the entry before this cycle's write
   always_ff @(posedge clock) begin
      if (cmd.lit_step) begin
         ls_mem[lit_ff] <= out_count_ff + CW'(1);
      end
      ls_rd_ff  <= ls_mem[lit_ff];
      vld_rd_ff <= valid_ff[lit_ff];
   end

   // history memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_mem[out_count_ff[AW-1:0]] <= wr_byte;
      end
      if (cmd.copy_rd) begin
         hist_rd_ff <= hist_mem[src_ff[AW-1:0]];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_bytes       = out_bytes_ff;
   assign rsp_byte_count  = out_cnt_ff;
   assign rsp_block_done  = out_done_ff;
   assign rsp_short_block = out_short_ff;
   assign rsp_run_end     = out_end_ff;

endmodule

// File: hw/rtl/rtime_decompressor.sv
// rtime_decompressor: one pair word at a time: accept, emit the literal, look
// up the copy source, a history read and write per copied byte, full words
// sent mid-run, last word flushed, sends waiting on result-side stalls; a
// pair after a finished block is dropped, one at length only flushes.
// The last result word is valid in the cycle the next pair word can be taken.
// Synchronous active-high reset: block open, count zero, length 4096.
module rtime_decompressor #(
   parameter int MAX_BLOCK = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   rtd_req_if.sink                  req_ch,
   rtd_rsp_if.source                rsp_ch,
   input  logic                     csr_wr_en,
   input  logic [rtd_pkg::CfgW-1:0] csr_wr_data
);

   rtd_pkg::cmd_type cmd;
   rtd_pkg::sts_type sts;
   logic [rtd_pkg::PackBytes-1:0][rtd_pkg::ByteW-1:0] rsp_bytes;

   // sequencer
   rtd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // memories, counters and output register
   rtd_datapath #(
      .MAX_BLOCK (MAX_BLOCK)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_first_pair   (req_ch.first_pair),
      .req_literal      (req_ch.literal),
      .req_repeat_count (req_ch.repeat_count),
      .req_last_pair    (req_ch.last_pair),
      .cmd              (cmd),
      .sts              (sts),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_bytes        (rsp_bytes),
      .rsp_byte_count   (rsp_ch.byte_count),
      .rsp_block_done   (rsp_ch.block_done),
      .rsp_short_block  (rsp_ch.short_block),
      .rsp_run_end      (rsp_ch.run_end)
   );

   assign rsp_ch.byte_a = rsp_bytes[0];
   assign rsp_ch.byte_b = rsp_bytes[1];
   assign rsp_ch.byte_c = rsp_bytes[2];
   assign rsp_ch.byte_d = rsp_bytes[3];

   // only the last word of a pair may be partly filled
   a_mid_word_full: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.run_end |-> rsp_ch.byte_count == 3'd4)
      else $error("result word before the end of a pair is not full");

   // block flags only ride on the last word of a pair
   a_done_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.block_done |-> rsp_ch.run_end)
      else $error("block_done without run_end");

   a_short_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.short_block |-> rsp_ch.block_done)
      else $error("short_block without block_done");

   // an empty word only comes from a block already at its length
   a_empty_is_done: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.byte_count == 3'd0 |-> rsp_ch.block_done && !rsp_ch.short_block)
      else $error("empty result word that does not close a full block");

endmodule
